// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define PTL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define PTL_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ptl_pkg.sv =====
// ----------------------------------------------------------------------------
// ptl_pkg
// Shared constants and types of the point-to-line distance pipeline.
// ----------------------------------------------------------------------------
package ptl_pkg;

    localparam int COORD_WIDTH_DEF = 32;

    // sideband that travels with each word down the pipe
    typedef struct packed {
        logic vld;
        logic degen;
        logic sat;
    } t_side;

endpackage

// ===== design/ptl_divider.sv =====
// ----------------------------------------------------------------------------
// ptl_divider
// Pipelined restoring divider, one quotient bit per stage, with overflow test.
// ----------------------------------------------------------------------------
module ptl_divider #(
    parameter int NW  = 136,
    parameter int DNW = 66,
    parameter int QW  = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  ptl_pkg::t_side       i_side,
    input  logic [NW-1:0]        i_num,
    input  logic [DNW-1:0]       i_den,
    output ptl_pkg::t_side       o_side,
    output logic [QW-1:0]        o_quo
);
    import ptl_pkg::*;

    localparam int HIW = NW - QW;

    t_side          p_side [0:QW];
    logic [DNW-1:0] p_rem  [0:QW];
    logic [DNW-1:0] p_den  [0:QW];
    logic [QW-1:0]  p_lo   [0:QW];
    logic [QW-1:0]  p_quo  [0:QW];

    logic [HIW-1:0] w_hi;
    logic           w_sat;

    assign w_hi  = i_num[NW-1:QW];
    // result would need more than QW bits
    assign w_sat = (w_hi >= HIW'(i_den));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            p_side[0].vld <= 1'b0;
        end else if (i_en) begin
            p_side[0].vld <= i_side.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            p_side[0].degen <= i_side.degen;
            p_side[0].sat   <= w_sat;
            p_rem[0]        <= w_sat ? '0 : w_hi[DNW-1:0];
            p_den[0]        <= i_den;
            p_lo[0]         <= i_num[QW-1:0];
            p_quo[0]        <= '0;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        logic [DNW:0] w_t;
        logic         w_ge;

        assign w_t  = {p_rem[k-1], p_lo[k-1][QW-1]};
        assign w_ge = (w_t >= {1'b0, p_den[k-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                p_side[k].vld <= 1'b0;
            end else if (i_en) begin
                p_side[k].vld <= p_side[k-1].vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                p_side[k].degen <= p_side[k-1].degen;
                p_side[k].sat   <= p_side[k-1].sat;
                p_rem[k]        <= w_ge ? DNW'(w_t - {1'b0, p_den[k-1]}) : w_t[DNW-1:0];
                p_den[k]        <= p_den[k-1];
                p_lo[k]         <= {p_lo[k-1][QW-2:0], 1'b0};
                p_quo[k]        <= {p_quo[k-1][QW-2:0], w_ge};
            end
        end
    end

    assign o_side = p_side[QW];
    assign o_quo  = p_quo[QW];

endmodule

// ===== design/ptl_sqrt.sv =====
// ----------------------------------------------------------------------------
// ptl_sqrt
// Pipelined integer square root, one root bit per stage, rounds toward zero.
// ----------------------------------------------------------------------------
module ptl_sqrt #(
    parameter int CW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  ptl_pkg::t_side       i_side,
    input  logic [2*CW-1:0]      i_val,
    output ptl_pkg::t_side       o_side,
    output logic [CW-1:0]        o_root
);
    import ptl_pkg::*;

    localparam int RW = CW + 2;

    t_side           p_side [0:CW];
    logic [RW-1:0]   p_rem  [0:CW];
    logic [CW-1:0]   p_root [0:CW];
    logic [2*CW-1:0] p_val  [0:CW];

    assign p_side[0] = i_side;
    assign p_rem[0]  = '0;
    assign p_root[0] = '0;
    assign p_val[0]  = i_val;

    for (genvar k = 1; k <= CW; k++) begin : g_stage
        logic [RW+1:0] w_t;
        logic [RW+1:0] w_trial;
        logic          w_ge;

        assign w_t     = {p_rem[k-1], p_val[k-1][2*CW-1 -: 2]};
        assign w_trial = (RW+2)'({p_root[k-1], 2'b01});
        assign w_ge    = (w_t >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                p_side[k].vld <= 1'b0;
            end else if (i_en) begin
                p_side[k].vld <= p_side[k-1].vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                p_side[k].degen <= p_side[k-1].degen;
                p_side[k].sat   <= p_side[k-1].sat;
                p_rem[k]        <= w_ge ? RW'(w_t - w_trial) : w_t[RW-1:0];
                p_root[k]       <= {p_root[k-1][CW-2:0], w_ge};
                p_val[k]        <= {p_val[k-1][2*CW-3:0], 2'b00};
            end
        end
    end

    assign o_side = p_side[CW];
    assign o_root = p_root[CW];

endmodule

// ===== design/point_to_line_distance_3d.sv =====
// ----------------------------------------------------------------------------
// point_to_line_distance_3d
// Distance from a query point to the line through two points, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one word per query: nine signed coordinates (start,
//   end, query point, x/y/z each). Master stream returns one word per query:
//   the floored distance in tdata, degenerate and saturated flags in tuser.
//   The distance is sqrt(|w x v|^2 / |v|^2), with v = end - start and
//   w = query - start; for start == end it is |w| and degenerate is set.
//   Throughput: one word per cycle while the receiver does not stall.
//   Stages: six front stages (differences, products, cross terms, square
//   partials, square sums, numerator select), one overflow stage plus
//   2*COORD_WIDTH divider stages, COORD_WIDTH root stages and the output
//   register.
//   Reset (synchronous, active low) clears all valid bits; no clearing pass.
//   When the receiver stalls, the whole pipe holds and s_tready drops, so no
//   word is lost or repeated.
// ----------------------------------------------------------------------------
module point_to_line_distance_3d #(
    parameter int COORD_WIDTH = ptl_pkg::COORD_WIDTH_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // start_x, start_y, start_z, end_x, end_y, end_z, query_x, query_y, query_z
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]         i_s_tdata,
    input  logic                                       i_s_tvalid,
    output logic                                       o_s_tready,
    // distance
    output logic [((COORD_WIDTH+7)/8)*8-1:0]           o_m_tdata,
    // degenerate, saturated
    output logic [1:0]                                 o_m_tuser,
    output logic                                       o_m_tvalid,
    input  logic                                       i_m_tready
);
    import ptl_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int DW  = CW + 1;
    localparam int PW  = 2 * DW;
    localparam int MW  = PW;
    localparam int HW  = MW / 2;
    localparam int NW  = 2 * MW;
    localparam int DNW = PW;
    localparam int QW  = 2 * CW;
    localparam int OW  = ((CW + 7) / 8) * 8;

    logic w_en;
    logic r_out_vld;

    assign w_en       = !r_out_vld || i_m_tready;
    assign o_s_tready = w_en;

    logic [6:1] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[5:1], i_s_tvalid};
        end
    end

    // stage 1: v = end - start, w = query - start
    logic signed [DW-1:0] w_pt [9];
    logic signed [DW-1:0] r1_v [3];
    logic signed [DW-1:0] r1_w [3];

    for (genvar i = 0; i < 9; i++) begin : g_pt
        assign w_pt[i] = {i_s_tdata[i*CW+CW-1], i_s_tdata[i*CW +: CW]};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_v[i] <= w_pt[3+i] - w_pt[i];
                r1_w[i] <= w_pt[6+i] - w_pt[i];
            end
        end
    end

    // stage 2: cross-product terms and squares
    logic signed [PW-1:0] r2_p  [6];
    logic        [PW-1:0] r2_vv [3];
    logic        [PW-1:0] r2_ww [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_p[0] <= r1_v[1] * r1_w[2];
            r2_p[1] <= r1_v[2] * r1_w[1];
            r2_p[2] <= r1_v[2] * r1_w[0];
            r2_p[3] <= r1_v[0] * r1_w[2];
            r2_p[4] <= r1_v[0] * r1_w[1];
            r2_p[5] <= r1_v[1] * r1_w[0];
            for (int i = 0; i < 3; i++) begin
                r2_vv[i] <= r1_v[i] * r1_v[i];
                r2_ww[i] <= r1_w[i] * r1_w[i];
            end
        end
    end

    // stage 3: cross components as magnitudes, |v|^2, |w|^2
    logic signed [PW:0]   w3_d [3];
    logic        [MW-1:0] w3_m [3];
    logic        [MW-1:0] r3_m [3];
    logic        [DNW-1:0] r3_den;
    logic        [DNW-1:0] r3_wn;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w3_d[i] = r2_p[2*i] - r2_p[2*i+1];
            w3_m[i] = w3_d[i][PW] ? MW'(-w3_d[i]) : MW'(w3_d[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_m   <= w3_m;
            r3_den <= r2_vv[0] + r2_vv[1] + r2_vv[2];
            r3_wn  <= r2_ww[0] + r2_ww[1] + r2_ww[2];
        end
    end

    // stage 4: split squares into half-width partial products
    logic [MW-1:0]  r4_hh [3];
    logic [MW-1:0]  r4_hl [3];
    logic [MW-1:0]  r4_ll [3];
    logic [DNW-1:0] r4_den;
    logic [DNW-1:0] r4_wn;
    logic           r4_degen;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r4_hh[i] <= r3_m[i][MW-1:HW] * r3_m[i][MW-1:HW];
                r4_hl[i] <= r3_m[i][MW-1:HW] * r3_m[i][HW-1:0];
                r4_ll[i] <= r3_m[i][HW-1:0]  * r3_m[i][HW-1:0];
            end
            r4_den   <= r3_den;
            r4_wn    <= r3_wn;
            r4_degen <= (r3_den == '0);
        end
    end

    // stage 5: assemble each square
    logic [NW-1:0]  r5_sq [3];
    logic [DNW-1:0] r5_den;
    logic [DNW-1:0] r5_wn;
    logic           r5_degen;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r5_sq[i] <= (NW'(r4_hh[i]) << (2*HW)) + (NW'(r4_hl[i]) << (HW+1))
                          + NW'(r4_ll[i]);
            end
            r5_den   <= r4_den;
            r5_wn    <= r4_wn;
            r5_degen <= r4_degen;
        end
    end

    // stage 6: numerator and denominator of the squared distance
    logic [NW-1:0]  r6_num;
    logic [DNW-1:0] r6_den;
    logic           r6_degen;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_num   <= r5_degen ? NW'(r5_wn) : (r5_sq[0] + r5_sq[1] + r5_sq[2]);
            r6_den   <= r5_degen ? DNW'(1) : r5_den;
            r6_degen <= r5_degen;
        end
    end

    t_side         w_div_in;
    t_side         w_div_out;
    logic [QW-1:0] w_quo;
    t_side         w_sq_out;
    logic [CW-1:0] w_root;

    assign w_div_in = '{vld: r_vld[6], degen: r6_degen, sat: 1'b0};

    ptl_divider #(
        .NW  (NW),
        .DNW (DNW),
        .QW  (QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_side  (w_div_in),
        .i_num   (r6_num),
        .i_den   (r6_den),
        .o_side  (w_div_out),
        .o_quo   (w_quo)
    );

    ptl_sqrt #(
        .CW (CW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_side  (w_div_out),
        .i_val   (w_quo),
        .o_side  (w_sq_out),
        .o_root  (w_root)
    );

    // output register
    logic [CW-1:0] r_out_dist;
    logic          r_out_degen;
    logic          r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_sq_out.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_dist  <= w_sq_out.sat ? '1 : w_root;
            r_out_degen <= w_sq_out.degen;
            r_out_sat   <= w_sq_out.sat;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = OW'(r_out_dist);
    assign o_m_tuser  = {r_out_sat, r_out_degen};

endmodule

// ===== design/ptl_checker.sv =====
// ----------------------------------------------------------------------------
// ptl_checker
// Port-level checks of the distance pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptl_checker #(
    parameter int COORD_WIDTH = ptl_pkg::COORD_WIDTH_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]         i_s_tdata,
    input  logic                                       i_s_tvalid,
    input  logic                                       o_s_tready,
    input  logic [((COORD_WIDTH+7)/8)*8-1:0]           o_m_tdata,
    input  logic [1:0]                                 o_m_tuser,
    input  logic                                       o_m_tvalid,
    input  logic                                       i_m_tready
);
    import ptl_pkg::*;

    logic w_unused;
    assign w_unused = ^{i_s_tdata, i_s_tvalid};

    `PTL_ASSERT_NR(a_reset_clears, i_clk, !i_rst_n |=> !o_m_tvalid, "valid after reset")
    `PTL_ASSERT(a_stall_blocks, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready) |-> !o_s_tready, "input taken during stall")
    `PTL_ASSERT(a_sat_ones, i_clk, i_rst_n, (o_m_tvalid && o_m_tuser[1]) |-> (o_m_tdata[COORD_WIDTH-1:0] == '1), "saturated word not all ones")
    `PTL_ASSERT(a_hold, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)), "stalled word changed")

endmodule

bind point_to_line_distance_3d ptl_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ptl_checker (.*);
